// ===== hw/rtl/vrfe_pkg.sv =====
// vrfe_pkg: types and constants shared by the rectangle fill engine files
// no dependencies
package vrfe_pkg;

    localparam int SHIFT_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W = 16;
    localparam int COORD_W = 16;
    localparam int CHAN_W = 8;
    localparam int PX_W = 10;
    localparam int PY_W = 9;

    // request kinds
    localparam logic REQ_FILL = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RED_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SHIFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SHIFT  = 2'd3;

    localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 4'd11;
    localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 4'd6;
    localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 4'd0;
    localparam logic [SHIFT_W-1:0] FLAG_SHIFT_RST  = 4'd5;

    typedef struct packed {
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
        logic [SHIFT_W-1:0] flag_shift;
    } t_cfg;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_w;
        logic signed [COORD_W-1:0] rect_h;
        logic [CHAN_W-1:0]         red;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         blue;
        logic [PX_W-1:0]           pixel_x;
        logic [PY_W-1:0]           pixel_y;
    } t_req;

    typedef struct packed {
        logic             accepted;
        logic [PIX_W-1:0] pixel_data;
    } t_rsp;

endpackage

// ===== hw/rtl/vrfe_if.sv =====
// vrfe_if: valid/ready channels for requests, responses and config writes
// depends on vrfe_pkg
interface vrfe_req_if;
    logic            valid;
    logic            ready;
    vrfe_pkg::t_req  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface vrfe_rsp_if;
    logic            valid;
    logic            ready;
    vrfe_pkg::t_rsp  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface vrfe_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vrfe_pkg::CFG_IDX_W-1:0]      index;
    logic [vrfe_pkg::SHIFT_W-1:0]        data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/vram_rect_fill_engine_top.sv =====
// vram_rect_fill_engine_top: pixel store with rectangle fill and single pixel read
// states: a read passes CLIP, MUL, READ, RWAIT and DONE; a fill passes CLIP, MUL, FILL over
// the clipped area (one pixel written per cycle over the single store write port) and DONE;
// a rejected or empty fill, or a read outside the store, goes from CLIP straight to DONE
// throughput: one request at a time; next word taken once the response is in the output register
// reset clears control and shift registers; pixel store contents are undefined until filled
// depends on vrfe_pkg, vrfe_if, vrfe_pack
module vram_rect_fill_engine_top #(
    parameter int STORE_WIDTH  = 1024,
    parameter int STORE_HEIGHT = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vrfe_req_if.sink   i_req,
    vrfe_cfg_if.sink   i_cfg,
    vrfe_rsp_if.source o_rsp
);
    import vrfe_pkg::*;

    localparam int XW    = $clog2(STORE_WIDTH);
    localparam int YW    = $clog2(STORE_HEIGHT);
    localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [17:0] W_S = 18'(STORE_WIDTH);
    localparam logic signed [17:0] H_S = 18'(STORE_HEIGHT);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLIP  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_RWAIT = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state           r_state;
    t_cfg             r_cfg;
    t_req             r_req;
    logic             r_is_read;
    logic [XW-1:0]    r_col, r_x0, r_x1;
    logic [YW-1:0]    r_row, r_y1;
    logic [AW-1:0]    r_base;
    logic [PIX_W-1:0] r_color;
    logic [PIX_W-1:0] r_rdata;
    logic             r_res_acc;
    logic [PIX_W-1:0] r_res_pix;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [PIX_W-1:0] r_mem [DEPTH];

    logic [PIX_W-1:0]  w_color;
    logic signed [17:0] w_x, w_y, w_right, w_bottom;
    logic              w_reject, w_empty, w_rd_inside;
    logic [XW-1:0]     w_x0, w_x1;
    logic [YW-1:0]     w_y0, w_y1;
    logic [AW-1:0]     w_addr;
    logic              w_we, w_out_free, w_row_end, w_last;

    vrfe_pack u_pack (
        .i_cfg   (r_cfg),
        .i_red   (r_req.red),
        .i_green (r_req.green),
        .i_blue  (r_req.blue),
        .o_color (w_color)
    );

    // bounds test and clip of the latched rectangle
    always_comb begin
        w_x      = 18'(r_req.rect_x);
        w_y      = 18'(r_req.rect_y);
        w_right  = w_x + 18'(r_req.rect_w) - 18'sd1;
        w_bottom = w_y + 18'(r_req.rect_h) - 18'sd1;
        w_reject = (w_x >= W_S) || (w_y >= H_S) || w_right[17] || w_bottom[17];
        w_x0     = w_x[17] ? '0 : w_x[XW-1:0];
        w_y0     = w_y[17] ? '0 : w_y[YW-1:0];
        w_x1     = (w_right > W_S - 18'sd1) ? XW'(STORE_WIDTH - 1) : w_right[XW-1:0];
        w_y1     = (w_bottom > H_S - 18'sd1) ? YW'(STORE_HEIGHT - 1) : w_bottom[YW-1:0];
        w_empty  = (w_x1 < w_x0) || (w_y1 < w_y0);
        w_rd_inside = (32'(r_req.pixel_x) < 32'(STORE_WIDTH))
                   && (32'(r_req.pixel_y) < 32'(STORE_HEIGHT));
    end

    assign w_addr     = r_base + AW'(r_col);
    assign w_we       = (r_state == ST_FILL);
    assign w_row_end  = (r_col == r_x1);
    assign w_last     = w_row_end && (r_row == r_y1);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // pixel store, one port used for both fill writes and reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= r_color;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_shift   <= RED_SHIFT_RST;
            r_cfg.green_shift <= GREEN_SHIFT_RST;
            r_cfg.blue_shift  <= BLUE_SHIFT_RST;
            r_cfg.flag_shift  <= FLAG_SHIFT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_RED_SHIFT:   r_cfg.red_shift   <= i_cfg.data;
                CFG_GREEN_SHIFT: r_cfg.green_shift <= i_cfg.data;
                CFG_BLUE_SHIFT:  r_cfg.blue_shift  <= i_cfg.data;
                CFG_FLAG_SHIFT:  r_cfg.flag_shift  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= ST_CLIP;
                    end
                end
                ST_CLIP: begin
                    if (r_req.req_type == REQ_READ) begin
                        r_state <= w_rd_inside ? ST_MUL : ST_DONE;
                    end else begin
                        r_state <= (w_reject || w_empty) ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= r_is_read ? ST_READ : ST_FILL;
                end
                ST_FILL: begin
                    if (w_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_READ: begin
                    r_state <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    r_req <= i_req.data;
                end
            end
            ST_CLIP: begin
                r_is_read <= (r_req.req_type == REQ_READ);
                r_color   <= w_color;
                r_x0      <= w_x0;
                r_x1      <= w_x1;
                r_y1      <= w_y1;
                r_res_pix <= '0;
                if (r_req.req_type == REQ_READ) begin
                    r_col     <= XW'(r_req.pixel_x);
                    r_row     <= YW'(r_req.pixel_y);
                    r_res_acc <= w_rd_inside;
                end else begin
                    r_col     <= w_x0;
                    r_row     <= w_y0;
                    r_res_acc <= !w_reject;
                end
            end
            ST_MUL: begin
                r_base <= AW'(r_row * STORE_WIDTH);
            end
            ST_FILL: begin
                if (w_row_end) begin
                    r_col  <= r_x0;
                    r_row  <= r_row + YW'(1);
                    r_base <= r_base + AW'(STORE_WIDTH);
                end else begin
                    r_col <= r_col + XW'(1);
                end
            end
            ST_READ: ;
            ST_RWAIT: begin
                r_res_pix <= r_rdata;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out.accepted   <= r_res_acc;
                    r_out.pixel_data <= r_res_pix;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/vrfe_pack.sv =====
// vrfe_pack: packs 8-bit rgb into the 16-bit pixel format set by the shift registers
// depends on vrfe_pkg
module vrfe_pack (
    input  vrfe_pkg::t_cfg                    i_cfg,
    input  logic [vrfe_pkg::CHAN_W-1:0]       i_red,
    input  logic [vrfe_pkg::CHAN_W-1:0]       i_green,
    input  logic [vrfe_pkg::CHAN_W-1:0]       i_blue,
    output logic [vrfe_pkg::PIX_W-1:0]        o_color
);
    import vrfe_pkg::*;

    logic [PIX_W-1:0] w_r5, w_g5, w_b5, w_flag;

    // top five bits of each channel, bits pushed past the msb drop off
    assign w_r5   = PIX_W'(i_red[CHAN_W-1 -: 5]);
    assign w_g5   = PIX_W'(i_green[CHAN_W-1 -: 5]);
    assign w_b5   = PIX_W'(i_blue[CHAN_W-1 -: 5]);
    assign w_flag = PIX_W'(1);

    assign o_color = (w_flag << i_cfg.flag_shift) | (w_r5 << i_cfg.red_shift)
                   | (w_g5 << i_cfg.green_shift) | (w_b5 << i_cfg.blue_shift);

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for vram_rect_fill_engine_top, fills and pixel reads
// checked against a shadow pixel store; needs vrfe_pkg, vrfe_if and the engine rtl
`timescale 1ns / 100ps

module tb_top;
    import vrfe_pkg::*;

    localparam int STORE_W = 1024;
    localparam int STORE_H = 512;
    localparam int QUIET_LIMIT = 50000;

    // shadow of the pixel store plus the responses still owed by the engine
    class rect_fill_checker;
        logic [SHIFT_W-1:0] shift_r;
        logic [SHIFT_W-1:0] shift_g;
        logic [SHIFT_W-1:0] shift_b;
        logic [SHIFT_W-1:0] shift_f;
        logic [PIX_W-1:0]   shadow_px[int];
        int                 filled_ofs[$];
        t_rsp               pending_rsp[$];
        int                 rsp_count;
        int                 fails;

        function new();
            shift_r   = RED_SHIFT_RST;
            shift_g   = GREEN_SHIFT_RST;
            shift_b   = BLUE_SHIFT_RST;
            shift_f   = FLAG_SHIFT_RST;
            rsp_count = 0;
            fails     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SHIFT_W-1:0] val);
            case (idx)
                CFG_RED_SHIFT:   shift_r = val;
                CFG_GREEN_SHIFT: shift_g = val;
                CFG_BLUE_SHIFT:  shift_b = val;
                CFG_FLAG_SHIFT:  shift_f = val;
                default: ;
            endcase
        endfunction

        // bounds test and clip; returns 0 when the fill is rejected
        static function bit clip_rect(input t_req r, output int x0, output int y0,
                                      output int x1, output int y1);
            x0 = $signed(r.rect_x);
            y0 = $signed(r.rect_y);
            x1 = x0 + $signed(r.rect_w) - 1;
            y1 = y0 + $signed(r.rect_h) - 1;
            if (x0 >= STORE_W || y0 >= STORE_H || x1 < 0 || y1 < 0) return 1'b0;
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > STORE_W - 1) x1 = STORE_W - 1;
            if (y1 > STORE_H - 1) y1 = STORE_H - 1;
            return 1'b1;
        endfunction

        function logic [PIX_W-1:0] pack_colour(t_req r);
            int unsigned c;
            c = 32'd1 << shift_f;
            c = c | ((32'(r.red) >> 3) << shift_r);
            c = c | ((32'(r.green) >> 3) << shift_g);
            c = c | ((32'(r.blue) >> 3) << shift_b);
            return c[PIX_W-1:0];
        endfunction

        function void note_req(t_req r);
            t_rsp             e;
            int               x0, y0, x1, y1, ofs;
            logic [PIX_W-1:0] c;
            e.accepted   = 1'b1;
            e.pixel_data = '0;
            if (r.req_type == REQ_READ) begin
                ofs = int'(r.pixel_y) * STORE_W + int'(r.pixel_x);
                if (shadow_px.exists(ofs)) e.pixel_data = shadow_px[ofs];
            end else if (!clip_rect(r, x0, y0, x1, y1)) begin
                e.accepted = 1'b0;
            end else begin
                c = pack_colour(r);
                for (int row = y0; row <= y1; row++) begin
                    for (int col = x0; col <= x1; col++) begin
                        ofs = row * STORE_W + col;
                        if (!shadow_px.exists(ofs)) filled_ofs.push_back(ofs);
                        shadow_px[ofs] = c;
                    end
                end
            end
            pending_rsp.push_back(e);
        endfunction

        function int pick_filled();
            return filled_ofs[$urandom_range(filled_ofs.size() - 1)];
        endfunction

        task log_miss(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        task check_rsp(t_rsp got);
            t_rsp e;
            rsp_count++;
            if (pending_rsp.size() == 0) begin
                log_miss($sformatf("response word %0d with nothing outstanding", rsp_count));
                return;
            end
            e = pending_rsp.pop_front();
            if (got.accepted !== e.accepted)
                log_miss($sformatf("response word %0d accepted %b, want %b",
                                   rsp_count, got.accepted, e.accepted));
            if (got.pixel_data !== e.pixel_data)
                log_miss($sformatf("response word %0d pixel_data %h, want %h",
                                   rsp_count, got.pixel_data, e.pixel_data));
        endtask
    endclass

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic rcv_ready = 1'b0;
    int   snd_idle  = 7;
    int   rcv_idle  = 73;
    int   quiet     = 0;
    rect_fill_checker book;

    vrfe_req_if req_if();
    vrfe_cfg_if cfg_if();
    vrfe_rsp_if rsp_if();

    vram_rect_fill_engine_top #(
        .STORE_WIDTH (STORE_W),
        .STORE_HEIGHT(STORE_H)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .i_cfg  (cfg_if),
        .o_rsp  (rsp_if)
    );

    assign rsp_if.ready = rcv_ready;

    always #2 i_clk = ~i_clk;

    // response side: random stall, check, and the no-progress watchdog
    always @(posedge i_clk) begin
        rcv_ready <= ($urandom_range(99) >= rcv_idle);
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) book.check_rsp(rsp_if.data);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    function automatic t_req noise_req();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_req)-1:0];
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle) gap++;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        book.note_req(r);
    endtask

    task automatic fill_rect(int x, int y, int w, int h, logic [7:0] cr, logic [7:0] cg,
                             logic [7:0] cb);
        t_req r;
        r          = noise_req();
        r.req_type = REQ_FILL;
        r.rect_x   = 16'(x);
        r.rect_y   = 16'(y);
        r.rect_w   = 16'(w);
        r.rect_h   = 16'(h);
        r.red      = cr;
        r.green    = cg;
        r.blue     = cb;
        send_req(r);
    endtask

    task automatic read_px(int px, int py);
        t_req r;
        r          = noise_req();
        r.req_type = REQ_READ;
        r.pixel_x  = PX_W'(px);
        r.pixel_y  = PY_W'(py);
        send_req(r);
    endtask

    // hold the request side until every response is back
    task automatic drain_rsp();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_shifts(logic [SHIFT_W-1:0] rs, logic [SHIFT_W-1:0] gs,
                                logic [SHIFT_W-1:0] bs, logic [SHIFT_W-1:0] fs);
        logic [SHIFT_W-1:0]   vals[4];
        logic [CFG_IDX_W-1:0] idxs[4];
        vals = '{rs, gs, bs, fs};
        idxs = '{CFG_RED_SHIFT, CFG_GREEN_SHIFT, CFG_BLUE_SHIFT, CFG_FLAG_SHIFT};
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idxs[i];
            cfg_if.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_if.ready);
            book.set_reg(idxs[i], vals[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        t_req r;
        int   kind, ofs, x, y, w, h, x0, y0, x1, y1;
        book = new();
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: widest row, tallest column, clipping on every side, rejects, empties
        fill_rect(0, 0, 32767, 1, 8'd255, 8'd0, 8'd0);
        fill_rect(1023, 0, 1, 32767, 8'd0, 8'd255, 8'd0);
        fill_rect(-5, -5, 10, 10, 8'd0, 8'd0, 8'd255);
        fill_rect(1020, 508, 32767, 32767, 8'd255, 8'd255, 8'd255);
        fill_rect(-1, 10, 2, 1, 8'd7, 8'd8, 8'd9);
        fill_rect(-1, 0, 1, 5, 8'd1, 8'd2, 8'd3);
        fill_rect(3, -1, 4, 1, 8'd1, 8'd2, 8'd3);
        fill_rect(1024, 0, 1, 1, 8'd1, 8'd2, 8'd3);
        fill_rect(0, 512, 1, 1, 8'd1, 8'd2, 8'd3);
        fill_rect(32767, 32767, 32767, 32767, 8'd1, 8'd2, 8'd3);
        fill_rect(-32768, -32768, -32768, -32768, 8'd1, 8'd2, 8'd3);
        fill_rect(100, 100, -50, 3, 8'd40, 8'd50, 8'd60);
        fill_rect(100, 100, 3, 0, 8'd40, 8'd50, 8'd60);
        fill_rect(0, 0, 0, 0, 8'd40, 8'd50, 8'd60);
        fill_rect(7, 9, 1, 1, 8'd0, 8'd0, 8'd0);
        read_px(0, 0);
        read_px(1023, 0);
        read_px(1023, 511);
        read_px(1020, 508);
        read_px(0, 10);
        read_px(7, 9);
        read_px(512, 0);
        read_px(1023, 300);

        for (int ph = 0; ph < 6; ph++) begin
            snd_idle = (ph < 2) ? 7 : (ph < 4) ? 73 : 0;
            rcv_idle = (ph < 2) ? 73 : (ph < 4) ? 7 : 0;
            drain_rsp();
            repeat (4) @(posedge i_clk);
            case (ph)
                0: write_shifts('0, '0, '0, '0);
                1: write_shifts('1, '1, '1, '1);
                5: write_shifts(RED_SHIFT_RST, GREEN_SHIFT_RST, BLUE_SHIFT_RST, FLAG_SHIFT_RST);
                default: write_shifts(SHIFT_W'($urandom), SHIFT_W'($urandom),
                                      SHIFT_W'($urandom), SHIFT_W'($urandom));
            endcase
            for (int n = 0; n < 93; n++) begin
                if (n == 46) drain_rsp();
                r    = noise_req();
                kind = $urandom_range(99);
                if (kind < 40) begin
                    r.req_type = REQ_READ;
                    ofs        = book.pick_filled();
                    r.pixel_x  = PX_W'(ofs % STORE_W);
                    r.pixel_y  = PY_W'(ofs / STORE_W);
                end else begin
                    r.req_type = REQ_FILL;
                    if (kind < 78) begin
                        x = int'($urandom_range(1047)) - 12;
                        y = int'($urandom_range(535)) - 12;
                        w = int'($urandom_range(22)) - 2;
                        h = int'($urandom_range(22)) - 2;
                    end else if (kind < 88) begin
                        x = int'($urandom_range(1151)) - 64;
                        y = int'($urandom_range(639)) - 64;
                        w = int'($urandom_range(64, 1));
                        h = int'($urandom_range(64, 1));
                    end else if (kind < 91) begin
                        // wide strips, 1024 or more wide, starting at or left of the left edge
                        x = -int'($urandom_range(200));
                        y = int'($urandom_range(520)) - 4;
                        w = int'($urandom_range(32767, 1024));
                        h = int'($urandom_range(8, 1));
                    end else begin
                        // raw fields; keep only rejects or modest areas
                        while (rect_fill_checker::clip_rect(r, x0, y0, x1, y1) &&
                               (x1 - x0 + 1) * (y1 - y0 + 1) > 4096) begin
                            r.rect_x = 16'($urandom);
                            r.rect_y = 16'($urandom);
                            r.rect_w = 16'($urandom);
                            r.rect_h = 16'($urandom);
                        end
                        x = $signed(r.rect_x);
                        y = $signed(r.rect_y);
                        w = $signed(r.rect_w);
                        h = $signed(r.rect_h);
                    end
                    r.rect_x = 16'(x);
                    r.rect_y = 16'(y);
                    r.rect_w = 16'(w);
                    r.rect_h = 16'(h);
                end
                send_req(r);
            end
        end

        drain_rsp();
        repeat (20) @(posedge i_clk);
        if (book.fails == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
